// ----- design/rmf_pkg.sv -----
`default_nettype none
package rmf_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DIM_W         = 13;
  localparam int COORD_W       = 12;
  localparam int CHAN_W        = 8;
  localparam int PIX_W         = 3 * CHAN_W;
  localparam int OUT_W         = PIX_W + 2 * COORD_W;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // element 3*j+k: column j (left to right), row k (top to bottom)
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    win_t               win;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } qent_t;

  function automatic logic [CHAN_W-1:0] chan(input pix_t p, input int ch);
    logic [PIX_W-1:0] bits;
    bits = p;
    return bits[CHAN_W*ch +: CHAN_W];
  endfunction

  function automatic logic [CHAN_W-1:0] min8(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CHAN_W-1:0] max8(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [CHAN_W-1:0] med3(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b,
                                             input logic [CHAN_W-1:0] c);
    return max8(min8(a, b), min8(max8(a, b), c));
  endfunction

endpackage
`default_nettype wire

// ----- design/rmf_queue.sv -----
`default_nettype none
module rmf_queue #(
  parameter int DEPTH = rmf_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rmf_pkg::qent_t push_data,
  output logic               full,
  input  wire logic          pop,
  output rmf_pkg::qent_t     pop_data,
  output logic               empty
);
  import rmf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  qent_t          slots [DEPTH];
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [NW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == NW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
      end
      if (do_pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- design/rmf_front.sv -----
`default_nettype none
module rmf_front #(
  parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [rmf_pkg::DIM_W-1:0] frame_width,
  input  wire logic [rmf_pkg::DIM_W-1:0] frame_height,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire rmf_pkg::pix_t             s_pix,
  input  wire logic                      q_full,
  output logic                           q_push,
  output rmf_pkg::qent_t                 q_data
);
  import rmf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int DW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int XW = (CW > COORD_W) ? CW : COORD_W;

  logic [DW-1:0]      fw_ext;
  logic [DW-1:0]      w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [DW-1:0]      c_inc;
  logic [DIM_W-1:0]   r_inc;
  logic [CW-1:0]      col;
  logic [CW-1:0]      col_next;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] row_next;
  logic [XW-1:0]      col_m1;
  logic               emit_now;
  logic               last_now;
  logic               accept;
  logic               f1_adv;

  logic               f1_valid;
  pix_t               f1_pix;
  logic [CW-1:0]      f1_col;
  logic [COORD_W-1:0] f1_ocol;
  logic [COORD_W-1:0] f1_orow;
  logic               f1_emit;
  logic               f1_last;

  pix_t               line_a [MAX_WIDTH];
  pix_t               line_b [MAX_WIDTH];
  pix_t               rd_a;
  pix_t               rd_b;
  pix_t [5:0]         wc;

  // effective frame size and raster position
  always_comb begin
    fw_ext = DW'(frame_width);
    if (fw_ext < DW'(3)) begin
      w_eff = DW'(3);
    end else if (fw_ext > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (frame_height < DIM_W'(3)) begin
      h_eff = DIM_W'(3);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    c_inc = DW'(col) + DW'(1);
    r_inc = DIM_W'(row) + DIM_W'(1);
    if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = (r_inc >= h_eff) ? '0 : r_inc[COORD_W-1:0];
    end else begin
      col_next = c_inc[CW-1:0];
      row_next = (DIM_W'(row) >= h_eff) ? '0 : row;
    end
    emit_now = (col >= CW'(2)) && (row >= COORD_W'(2));
    last_now = (DW'(col) == w_eff - DW'(1)) && (DIM_W'(row) == h_eff - DIM_W'(1));
    col_m1   = XW'(col) - XW'(1);
  end

  assign f1_adv   = f1_valid && (!f1_emit || !q_full);
  assign s_tready = !rst && (!f1_valid || f1_adv);
  assign accept   = s_tvalid && s_tready;
  assign q_push   = f1_adv && f1_emit;

  always_comb begin
    q_data.win[0] = wc[0];
    q_data.win[1] = wc[1];
    q_data.win[2] = wc[2];
    q_data.win[3] = wc[3];
    q_data.win[4] = wc[4];
    q_data.win[5] = wc[5];
    q_data.win[6] = rd_b;
    q_data.win[7] = rd_a;
    q_data.win[8] = f1_pix;
    q_data.col    = f1_ocol;
    q_data.row    = f1_orow;
    q_data.last   = f1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      f1_valid <= 1'b0;
      wc       <= '0;
    end else begin
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
      f1_valid <= accept || (f1_valid && !f1_adv);
      if (f1_adv) begin
        wc[0] <= wc[3];
        wc[1] <= wc[4];
        wc[2] <= wc[5];
        wc[3] <= rd_b;
        wc[4] <= rd_a;
        wc[5] <= f1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pix  <= s_pix;
      f1_col  <= col;
      f1_ocol <= col_m1[COORD_W-1:0];
      f1_orow <= row - COORD_W'(1);
      f1_emit <= emit_now;
      f1_last <= last_now;
    end
  end

  // line stores: row r-1 in line_a, row r-2 in line_b
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= line_a[col];
      rd_b <= line_b[col];
    end
    if (f1_adv) begin
      line_a[f1_col] <= f1_pix;
      line_b[f1_col] <= rd_a;
    end
  end

endmodule
`default_nettype wire

// ----- design/rmf_back.sv -----
`default_nettype none
module rmf_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_empty,
  input  wire rmf_pkg::qent_t            q_data,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [rmf_pkg::OUT_W-1:0]      m_tdata,
  output logic                           m_tlast
);
  import rmf_pkg::*;

  logic                          en;
  logic                          s1_v;
  logic                          s2_v;
  logic [2:0][2:0][CHAN_W-1:0]   s1_lo;
  logic [2:0][2:0][CHAN_W-1:0]   s1_md;
  logic [2:0][2:0][CHAN_W-1:0]   s1_hi;
  logic [2:0][CHAN_W-1:0]        s2_lo;
  logic [2:0][CHAN_W-1:0]        s2_md;
  logic [2:0][CHAN_W-1:0]        s2_hi;
  logic [COORD_W-1:0]            s1_col;
  logic [COORD_W-1:0]            s1_row;
  logic                          s1_last;
  logic [COORD_W-1:0]            s2_col;
  logic [COORD_W-1:0]            s2_row;
  logic                          s2_last;

  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      s1_v     <= !q_empty;
      s2_v     <= s1_v;
      m_tvalid <= s2_v;
    end
  end

  // sort each column, then max of mins, median of medians, min of maxes, and the median of those three
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int j = 0; j < 3; j++) begin
          s1_lo[ch][j] <= min8(min8(chan(q_data.win[3*j], ch), chan(q_data.win[3*j+1], ch)),
                               chan(q_data.win[3*j+2], ch));
          s1_hi[ch][j] <= max8(max8(chan(q_data.win[3*j], ch), chan(q_data.win[3*j+1], ch)),
                               chan(q_data.win[3*j+2], ch));
          s1_md[ch][j] <= med3(chan(q_data.win[3*j], ch), chan(q_data.win[3*j+1], ch),
                               chan(q_data.win[3*j+2], ch));
        end
        s2_lo[ch] <= max8(max8(s1_lo[ch][0], s1_lo[ch][1]), s1_lo[ch][2]);
        s2_md[ch] <= med3(s1_md[ch][0], s1_md[ch][1], s1_md[ch][2]);
        s2_hi[ch] <= min8(min8(s1_hi[ch][0], s1_hi[ch][1]), s1_hi[ch][2]);
        m_tdata[CHAN_W*(2-ch) +: CHAN_W] <= med3(s2_lo[ch], s2_md[ch], s2_hi[ch]);
      end
      s1_col  <= q_data.col;
      s1_row  <= q_data.row;
      s1_last <= q_data.last;
      s2_col  <= s1_col;
      s2_row  <= s1_row;
      s2_last <= s1_last;
      m_tdata[PIX_W +: COORD_W]           <= s2_col;
      m_tdata[PIX_W + COORD_W +: COORD_W] <= s2_row;
      m_tlast <= s2_last;
    end
  end

endmodule
`default_nettype wire

// ----- design/rgb_median_filter_3x3.sv -----
// channel  | dir | beat contents
// s_*      | in  | one raster-order rgb pixel
// m_*      | out | channel medians and centre position of one interior pixel
// apb      | in  | frame_width at 0x0, frame_height at 0x4
//
// one pixel per cycle sustained while m_tready is high; line stores are read
// and written once per pixel and the median network is a three-stage pipeline
// the completing beat passes the front register, queue, s1 and s2 to m_tvalid
// reset clears the raster position and window; line stores are not cleared
// s_tready is low in reset, else drops only while the four-entry window queue
// is full and the front holds a pixel that gives a result
`default_nettype none
module rgb_median_filter_3x3 #(
  parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [23:0]               s_tdata,   // in_red, in_green, in_blue
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [rmf_pkg::OUT_W-1:0]      m_tdata,   // med_red, med_green, med_blue,
                                                    // centre_col, centre_row
  output logic                           m_tlast,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rmf_pkg::*;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             cfg_wr;
  pix_t             s_pix;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  qent_t            q_in;
  qent_t            q_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        default:    frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    s_pix.red   = s_tdata[7:0];
    s_pix.green = s_tdata[15:8];
    s_pix.blue  = s_tdata[23:16];
  end

  rmf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_pix        (s_pix),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  rmf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  rmf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ----- tb/rmf_tb_pkg.sv -----
`timescale 1ns / 100ps
package rmf_tb_pkg;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'h0,
    REG_FRAME_HEIGHT = 3'h4
  } reg_addr_t;

  // register value to the frame size actually used
  function automatic int unsigned clamp_dim(input logic [12:0] value, input int unsigned hi);
    if (value < 3) return 3;
    if (value > hi) return hi;
    return value;
  endfunction

endpackage

// ----- tb/rmf_checker.sv -----
`timescale 1ns / 100ps
module rmf_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [23:0]                  s_tdata,   // in_red, in_green, in_blue
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [rmf_pkg::OUT_W-1:0]    m_tdata,   // med_red, med_green, med_blue,
                                                  // centre_col, centre_row
  input  logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  output int                           errors,
  output int                           pending
);
  import rmf_pkg::*;
  import rmf_tb_pkg::*;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
  } median_beat_t;

  median_beat_t     medians_due[$];
  median_beat_t     due;
  pix_t             two_up [MAX_WIDTH_DEF];
  pix_t             one_up [MAX_WIDTH_DEF];
  pix_t             win_cols [6];
  int unsigned      col_at;
  int unsigned      row_at;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  int               fail_count = 0;

  function automatic logic [7:0] median_of_nine(input logic [71:0] packed_vals);
    logic [7:0] v [9];
    logic [7:0] t;
    int j;
    for (int i = 0; i < 9; i++) v[i] = packed_vals[8*i +: 8];
    for (int i = 1; i < 9; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > t) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = t;
    end
    return v[4];
  endfunction

  task automatic predict_pixel(input logic [23:0] data);
    pix_t pix;
    pix_t top_px;
    pix_t mid_px;
    pix_t px [9];
    logic [71:0] reds;
    logic [71:0] greens;
    logic [71:0] blues;
    int unsigned w;
    int unsigned h;
    median_beat_t beat;
    pix.red   = data[7:0];
    pix.green = data[15:8];
    pix.blue  = data[23:16];
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    top_px = '0;
    mid_px = '0;
    if (col_at < MAX_WIDTH_DEF) begin
      top_px = two_up[col_at];
      mid_px = one_up[col_at];
      two_up[col_at] = mid_px;
      one_up[col_at] = pix;
    end
    for (int k = 0; k < 6; k++) px[k] = win_cols[k];
    px[6] = top_px;
    px[7] = mid_px;
    px[8] = pix;
    if (col_at >= 2 && row_at >= 2) begin
      for (int k = 0; k < 9; k++) begin
        reds[8*k +: 8]   = px[k].red;
        greens[8*k +: 8] = px[k].green;
        blues[8*k +: 8]  = px[k].blue;
      end
      beat.red   = median_of_nine(reds);
      beat.green = median_of_nine(greens);
      beat.blue  = median_of_nine(blues);
      beat.col   = 12'(col_at - 1);
      beat.row   = 12'(row_at - 1);
      beat.last  = (col_at == w - 1) && (row_at == h - 1);
      medians_due.push_back(beat);
    end
    for (int k = 0; k < 3; k++) win_cols[k] = win_cols[k + 3];
    win_cols[3] = top_px;
    win_cols[4] = mid_px;
    win_cols[5] = pix;
    col_at++;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
      if (row_at >= h) row_at = 0;
    end else if (row_at >= h) begin
      row_at = 0;
    end
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      medians_due.delete();
      for (int k = 0; k < 6; k++) win_cols[k] = '0;
      col_at = 0;
      row_at = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == REG_FRAME_WIDTH) width_reg = pwdata[DIM_W-1:0];
          else if (paddr == REG_FRAME_HEIGHT) height_reg = pwdata[DIM_W-1:0];
        end else if (paddr == REG_FRAME_WIDTH) begin
          check_field("frame_width readback", width_reg, prdata);
        end else if (paddr == REG_FRAME_HEIGHT) begin
          check_field("frame_height readback", height_reg, prdata);
        end
      end
      if (m_tvalid && m_tready) begin
        if (medians_due.size() == 0) begin
          $error("median beat with none expected: col %0d row %0d",
                 m_tdata[35:24], m_tdata[47:36]);
          fail_count++;
        end else begin
          due = medians_due.pop_front();
          check_field("med_red", due.red, m_tdata[7:0]);
          check_field("med_green", due.green, m_tdata[15:8]);
          check_field("med_blue", due.blue, m_tdata[23:16]);
          check_field("centre_col", due.col, m_tdata[35:24]);
          check_field("centre_row", due.row, m_tdata[47:36]);
          check_field("frame_last", due.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) predict_pixel(s_tdata);
    end
    errors  <= fail_count;
    pending <= medians_due.size();
  end

endmodule

// ----- tb/tb_rgb_median_filter_3x3.sv -----
`timescale 1ns / 100ps
module tb_rgb_median_filter_3x3;
  import rmf_pkg::*;
  import rmf_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_PIXELS = 1250;
  localparam int DRAIN_CYCLES  = 20;

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [23:0]        s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               m_tlast;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;

  int                 cycles = 0;
  int                 idle_max = 15;
  bit                 coarse_pixels = 1'b0;
  int                 pixels_sent = 0;
  int                 geometries = 0;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  int unsigned        eff_w = 640;
  int unsigned        eff_h = 480;

  rgb_median_filter_3x3 dut (.*);
  rmf_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rgb_median_filter_3x3");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = $urandom_range(0, idle_max);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic apb_access(input bit is_write, input reg_addr_t addr,
                            input logic [12:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= {($urandom_range(0, 3) == 0) ? 19'($urandom) : 19'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (is_write) begin
      if (addr == REG_FRAME_WIDTH) eff_w = clamp_dim(value, MAX_WIDTH_DEF);
      else eff_h = clamp_dim(value, MAX_HEIGHT);
    end
  endtask

  task automatic send_pixel(input logic [23:0] data);
    int gap;
    gap = $urandom_range(0, idle_max);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= data;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    pixels_sent++;
    col_pos++;
    if (col_pos >= eff_w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= eff_h) row_pos = 0;
    end else if (row_pos >= eff_h) begin
      row_pos = 0;
    end
  endtask

  function automatic logic [7:0] rand_chan();
    if (coarse_pixels) return ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1));
    return 8'($urandom);
  endfunction

  // pixels until the raster position is back at the frame origin
  task automatic run_to_frame_end();
    do send_pixel({rand_chan(), rand_chan(), rand_chan()});
    while (col_pos != 0 || row_pos != 0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int random_start;
    int partial;
    logic [12:0] next_w;
    logic [12:0] next_h;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_access(1'b0, REG_FRAME_WIDTH, '0);
    apb_access(1'b0, REG_FRAME_HEIGHT, '0);

    // smallest frame, a single interior pixel
    apb_access(1'b1, REG_FRAME_WIDTH, 13'd3);
    apb_access(1'b1, REG_FRAME_HEIGHT, 13'd3);
    geometries++;
    for (int i = 0; i < 9; i++)
      send_pixel({8'(255 - i * 31), 8'(i * 32), (i % 2) ? 8'hFF : 8'h00});
    wait_idle();

    // sizes below the minimum act as 3
    apb_access(1'b1, REG_FRAME_WIDTH, 13'd0);
    apb_access(1'b1, REG_FRAME_HEIGHT, 13'd2);
    apb_access(1'b0, REG_FRAME_WIDTH, '0);
    apb_access(1'b0, REG_FRAME_HEIGHT, '0);
    geometries++;
    for (int i = 0; i < 9; i++)
      send_pixel({8'hFF ^ 8'(1 << (i % 8)), (i < 5) ? 8'hFF : 8'h00, 8'(i * 29 + 13)});
    wait_idle();

    // resize in the middle of a frame: narrower, then shorter
    apb_access(1'b1, REG_FRAME_WIDTH, 13'd12);
    apb_access(1'b1, REG_FRAME_HEIGHT, 13'd8);
    geometries++;
    repeat (5 * 12 + 9) send_pixel({rand_chan(), rand_chan(), rand_chan()});
    wait_idle();
    apb_access(1'b1, REG_FRAME_WIDTH, 13'd6);
    repeat (3) send_pixel({rand_chan(), rand_chan(), rand_chan()});
    wait_idle();
    apb_access(1'b1, REG_FRAME_HEIGHT, 13'd4);
    run_to_frame_end();

    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      wait_idle();
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      coarse_pixels = ($urandom_range(0, 2) == 0);
      next_w = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 2))
                                           : 13'($urandom_range(3, 24));
      next_h = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 2))
                                           : 13'($urandom_range(3, 8));
      apb_access(1'b1, REG_FRAME_WIDTH, next_w);
      apb_access(1'b1, REG_FRAME_HEIGHT, next_h);
      apb_access(1'b0, $urandom_range(0, 1) ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT, '0);
      geometries++;
      if ($urandom_range(0, 3) == 0) begin
        partial = $urandom_range(1, eff_w * eff_h - 1);
        repeat (partial) send_pixel({rand_chan(), rand_chan(), rand_chan()});
        wait_idle();
        if ($urandom_range(0, 1))
          apb_access(1'b1, REG_FRAME_WIDTH, 13'($urandom_range(3, eff_w)));
        else
          apb_access(1'b1, REG_FRAME_HEIGHT, 13'($urandom_range(0, 10)));
        run_to_frame_end();
      end
      repeat ($urandom_range(1, 3)) run_to_frame_end();
    end
    wait_idle();

    $display("streamed %0d pixels over %0d frame geometries, from 3x3 up to 24 wide,",
             pixels_sent, geometries);
    $display("with mid-frame resizes, small clamped sizes, register readback and random stalls");
    if (errors == 0) begin
      $display("PASS rgb_median_filter_3x3");
    end else begin
      $display("FAIL rgb_median_filter_3x3");
    end
    $finish;
  end

endmodule
